[hdl/gfep_pkg.sv]
// ----------------------------------------------------------------------------
// gfep_pkg
// Shared constants, codes and GF(2^8) arithmetic for the parity encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gfep_pkg;

  // Default store geometry
  localparam int unsigned MAX_DATA_SHARES_DEF   = 32;
  localparam int unsigned MAX_PARITY_SHARES_DEF = 16;

  // Field widths of the transactions
  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned COL_W   = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PIDX_W  = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned DSC_W      = 6;
  localparam int unsigned PC_W       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SHARE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT     = 1'd1;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DATA = 1'b1;

  // Field polynomial x^8+x^4+x^3+x^2+1, low byte
  localparam logic [BYTE_W-1:0] GF_REDUCE = 8'h1D;

  // GF(2^8) product, shift-and-add over eight bits
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] p;
    x = a;
    p = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        p = p ^ x;
      end
      x = x[BYTE_W-1] ? ({x[BYTE_W-2:0], 1'b0} ^ GF_REDUCE) : {x[BYTE_W-2:0], 1'b0};
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[hdl/gfep_in_if.sv]
// ----------------------------------------------------------------------------
// gfep_in_if
// Input channel: coefficient loads and data bytes with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfep_in_if;
  logic                          valid;
  logic                          ready;
  logic [gfep_pkg::FUNC_W-1:0]   func;
  logic [gfep_pkg::ROW_W-1:0]    row;
  logic [gfep_pkg::COL_W-1:0]    col;
  logic [gfep_pkg::BYTE_W-1:0]   value;

  modport source (output valid, output func, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input func, input row, input col, input value,
                  output ready);
endinterface

`default_nettype wire

[hdl/gfep_out_if.sv]
// ----------------------------------------------------------------------------
// gfep_out_if
// Result channel: parity bytes with index and last flag, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfep_out_if;
  logic                          valid;
  logic                          ready;
  logic [gfep_pkg::PIDX_W-1:0]   parity_index;
  logic [gfep_pkg::BYTE_W-1:0]   parity_byte;
  logic                          last;

  modport source (output valid, output parity_index, output parity_byte, output last,
                  input ready);
  modport sink   (input valid, input parity_index, input parity_byte, input last,
                  output ready);
endinterface

`default_nettype wire

[hdl/gfep_ram.sv]
// ----------------------------------------------------------------------------
// gfep_ram
// Single-port synchronous RAM with per-lane write enables and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gfep_ram #(
  parameter int unsigned LANE_W = 8,
  parameter int unsigned LANES  = 16,
  parameter int unsigned DEPTH  = 32,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic [LANES-1:0]          we,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [LANES*LANE_W-1:0]   wdata,
  output logic      [LANES*LANE_W-1:0]   rdata
);

  logic [LANES*LANE_W-1:0] mem [DEPTH];

  // Write selected lanes, register the read word
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (we[l]) begin
        mem[addr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
      end
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[hdl/gf256_erasure_parity_encoder.sv]
// ----------------------------------------------------------------------------
// gf256_erasure_parity_encoder
// GF(2^8) erasure-code parity engine: per-share coefficient rows in RAM,
// all active parity rows multiply-accumulate in parallel, bursts out per column.
// ----------------------------------------------------------------------------
// Flow: a data byte that closes a column is held in stage 1 while its
//   coefficient row is read; the burst registers load as it leaves stage 1,
//   then the burst gives one parity byte per cycle while out_ch.ready is high.
// Throughput: one transaction per cycle; input stalls only while a column end
//   waits for the previous burst to leave.
// Reset (synchronous, active low): clears accumulators, share counter, the
//   pipeline and burst; both counts return to 1. The coefficient RAM is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_erasure_parity_encoder #(
  parameter int unsigned MAX_DATA_SHARES   = gfep_pkg::MAX_DATA_SHARES_DEF,
  parameter int unsigned MAX_PARITY_SHARES = gfep_pkg::MAX_PARITY_SHARES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  gfep_in_if.sink                                 in_ch,
  gfep_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [gfep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gfep_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned BW    = gfep_pkg::BYTE_W;
  localparam int unsigned AW    = (MAX_DATA_SHARES > 1) ? $clog2(MAX_DATA_SHARES) : 1;
  localparam int unsigned CNTW  = $clog2(MAX_DATA_SHARES + 1);
  localparam int unsigned CMPW  = 10;
  localparam int unsigned NPW   = $clog2(MAX_PARITY_SHARES + 1);
  localparam int unsigned IDXW  = (NPW > gfep_pkg::PC_W) ? NPW : gfep_pkg::PC_W;
  localparam int unsigned LANES = MAX_PARITY_SHARES;

  // Configuration registers
  logic [gfep_pkg::DSC_W-1:0] dsc_r;
  logic [gfep_pkg::PC_W-1:0]  pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsc_r <= gfep_pkg::DSC_W'(1);
      pc_r  <= gfep_pkg::PC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfep_pkg::CFG_DATA_SHARE_COUNT: dsc_r <= cfg_data[gfep_pkg::DSC_W-1:0];
        gfep_pkg::CFG_PARITY_COUNT:     pc_r  <= cfg_data[gfep_pkg::PC_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero reads as one, larger values saturate to the store geometry
  logic [CMPW-1:0] k_eff;
  logic [IDXW-1:0] np_eff;

  always_comb begin
    if (dsc_r == '0) begin
      k_eff = CMPW'(1);
    end else if (CMPW'(dsc_r) > CMPW'(MAX_DATA_SHARES)) begin
      k_eff = CMPW'(MAX_DATA_SHARES);
    end else begin
      k_eff = CMPW'(dsc_r);
    end
    if (pc_r == '0) begin
      np_eff = IDXW'(1);
    end else if (IDXW'(pc_r) > IDXW'(MAX_PARITY_SHARES)) begin
      np_eff = IDXW'(MAX_PARITY_SHARES);
    end else begin
      np_eff = IDXW'(pc_r);
    end
  end

  // Pipeline and burst registers
  logic                 s1_valid_r, s1_valid_nxt;
  logic [BW-1:0]        s1_byte_r,  s1_byte_nxt;
  logic                 s1_end_r,   s1_end_nxt;
  logic [CNTW-1:0]      share_cnt_r, share_cnt_nxt;
  logic [BW-1:0]        acc_r   [LANES];
  logic [BW-1:0]        acc_nxt [LANES];
  logic [BW-1:0]        burst_r [LANES];
  logic [IDXW-1:0]      bst_left_r, bst_left_nxt;
  logic [IDXW-1:0]      bst_idx_r,  bst_idx_nxt;

  logic                 in_fire, is_data, is_load, load_ok;
  logic                 s1_fire, buf_free, out_fire, bst_load;
  logic [CNTW-1:0]      cnt_use;
  logic                 col_end;
  logic [CMPW-1:0]      row_ext, col_ext;
  logic [LANES-1:0]     ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_addr;
  logic [LANES*BW-1:0]  ram_wdata, ram_rdata;
  logic [BW-1:0]        sum     [LANES];

  // Handshake and stage advance
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign buf_free    = (bst_left_r == '0) || (out_ch.ready && bst_left_r == IDXW'(1));
  assign s1_fire     = s1_valid_r && (!s1_end_r || buf_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_data     = in_fire && (in_ch.func == gfep_pkg::FUNC_DATA);
  assign is_load     = in_fire && (in_ch.func == gfep_pkg::FUNC_LOAD);
  assign bst_load    = s1_fire && s1_end_r;

  // Share position and column end
  assign cnt_use = (CMPW'(share_cnt_r) >= CMPW'(MAX_DATA_SHARES)) ?
                   CNTW'(MAX_DATA_SHARES - 1) : share_cnt_r;
  assign col_end = (CMPW'(cnt_use) + CMPW'(1)) >= k_eff;

  always_comb begin
    share_cnt_nxt = share_cnt_r;
    if (is_data) begin
      share_cnt_nxt = col_end ? '0 : CNTW'(CMPW'(cnt_use) + CMPW'(1));
    end
  end

  // Coefficient RAM: one row of all parity lanes per data share
  assign row_ext   = CMPW'(in_ch.row);
  assign col_ext   = CMPW'(in_ch.col);
  assign load_ok   = is_load && (row_ext < CMPW'(MAX_PARITY_SHARES)) &&
                     (col_ext < CMPW'(MAX_DATA_SHARES));
  assign ram_re    = is_data;
  assign ram_addr  = is_data ? cnt_use[AW-1:0] : col_ext[AW-1:0];
  assign ram_wdata = {LANES{in_ch.value}};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ram_we[l] = load_ok && (row_ext == CMPW'(l));
    end
  end

  gfep_ram #(
    .LANE_W (BW),
    .LANES  (LANES),
    .DEPTH  (MAX_DATA_SHARES)
  ) u_coeff_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Stage 1 holds the data byte while the coefficient row is read
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    s1_end_nxt   = s1_end_r;
    if (in_ch.ready) begin
      s1_valid_nxt = is_data;
      s1_byte_nxt  = in_ch.value;
      s1_end_nxt   = is_data && col_end;
    end
  end

  // Multiply-accumulate all active rows; clear at column end
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (IDXW'(l) < np_eff) begin
        sum[l] = acc_r[l] ^ gfep_pkg::gf_mul(ram_rdata[l*BW +: BW], s1_byte_r);
      end else begin
        sum[l] = acc_r[l];
      end
      acc_nxt[l] = acc_r[l];
      if (s1_fire) begin
        acc_nxt[l] = s1_end_r ? '0 : sum[l];
      end
    end
  end

  // Burst counters: load on column end, advance per output transaction
  always_comb begin
    bst_left_nxt = bst_left_r;
    bst_idx_nxt  = bst_idx_r;
    if (bst_load) begin
      bst_left_nxt = np_eff;
      bst_idx_nxt  = '0;
    end else if (out_fire) begin
      bst_left_nxt = bst_left_r - IDXW'(1);
      bst_idx_nxt  = bst_idx_r + IDXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_end_r    <= 1'b0;
      share_cnt_r <= '0;
      bst_left_r  <= '0;
      bst_idx_r   <= '0;
      for (int l = 0; l < LANES; l++) begin
        acc_r[l] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_end_r    <= s1_end_nxt;
      share_cnt_r <= share_cnt_nxt;
      bst_left_r  <= bst_left_nxt;
      bst_idx_r   <= bst_idx_nxt;
      for (int l = 0; l < LANES; l++) begin
        acc_r[l] <= acc_nxt[l];
      end
    end
  end

  // Payload: stage byte and burst shift line
  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    if (bst_load) begin
      for (int l = 0; l < LANES; l++) begin
        burst_r[l] <= sum[l];
      end
    end else if (out_fire) begin
      for (int l = 0; l + 1 < LANES; l++) begin
        burst_r[l] <= burst_r[l+1];
      end
    end
  end

  assign out_ch.valid        = (bst_left_r != '0);
  assign out_ch.parity_index = bst_idx_r[gfep_pkg::PIDX_W-1:0];
  assign out_ch.parity_byte  = burst_r[0];
  assign out_ch.last         = (bst_left_r == IDXW'(1));

  // Checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_end_r && !buf_free))
    else $error("input stalled without a pending column end");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> (!ram_re ##1 (s1_valid_r && $stable(s1_byte_r))))
    else $error("stalled stage lost its byte or coefficient row");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (bst_idx_r + IDXW'(1) == np_eff))
    else $error("last flag not on the final parity row");

  a_burst_restart: assert property (@(posedge clk) disable iff (!rst_n)
    bst_load |=> (out_ch.valid && bst_idx_r == '0))
    else $error("new burst does not start at parity row zero");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bst_load |=> (share_cnt_r == '0 || $past(is_data)))
    else $error("share counter not cleared with column end");

endmodule

`default_nettype wire
